// ===== sv/cnv5_pkg.sv =====
// Types and constants shared by the normalized 5x5 convolution filter.
`default_nettype none
package cnv5_pkg;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       frame_start;
  } pix_req_t;

  typedef struct packed {
    logic [7:0]  filtered_pixel;
    logic [10:0] center_row;
    logic [10:0] center_col;
  } flt_res_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic mac_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  localparam logic [2:0] REG_WROW0 = 3'd0;
  localparam logic [2:0] REG_WROW1 = 3'd1;
  localparam logic [2:0] REG_WROW2 = 3'd2;
  localparam logic [2:0] REG_WROW3 = 3'd3;
  localparam logic [2:0] REG_WROW4 = 3'd4;
  localparam logic [2:0] REG_WIDTH = 3'd5;

  localparam logic [39:0] RST_WROW      = 40'h0;
  localparam logic [39:0] RST_WROW2     = 40'h10000;
  localparam logic [11:0] RST_IMG_WIDTH = 12'd640;

endpackage
`default_nettype wire

// ===== sv/cnv5_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cnv5_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== sv/cnv5_ctrl.sv =====
// Controller state machine that sequences load, multiply-accumulate, divide and output.
`default_nettype none
module cnv5_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cnv5_pkg::dp_sts_t sts_i,
  output cnv5_pkg::dp_cmd_t      cmd_o
);
  import cnv5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MAC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.emit ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        if (sts_i.mac_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.mac_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== sv/cnv5_dp.sv =====
// Datapath: position counters, line store, window, multiply-accumulate, divider, output register.
`default_nettype none
module cnv5_dp #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cnv5_pkg::pix_req_t in_req_i,
  input  wire cnv5_pkg::dp_cmd_t  cmd_i,
  output cnv5_pkg::dp_sts_t       sts_o,
  input  wire logic [4:0][39:0]   weights_i,
  input  wire logic [11:0]        image_width_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output cnv5_pkg::flt_res_t      out_res_o
);
  import cnv5_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WB   = (WEIGHT_BITS < 8) ? WEIGHT_BITS : 8;
  localparam int PW   = WB + 9;
  localparam int ACCW = WB + 14;
  localparam int SW   = WB + 5;
  localparam int CNTW = $clog2(ACCW + 1);

  logic [AW:0]   wlim;
  logic [AW-1:0] col_q, col_d, pos_c_q, cur_c;
  logic [RW-1:0] row_q, row_d, pos_r_q, cur_r;
  logic [AW:0]   col_inc;
  logic [RW:0]   row_inc0, row_inc1;
  logic [7:0]    pix_q;
  logic          emit_q;
  logic [31:0]   ram_rdata;
  logic [39:0]   win_q [5];

  always_comb begin
    if (image_width_i < 12'd5) begin
      wlim = (AW+1)'(5);
    end else if ({20'd0, image_width_i} > 32'(MAX_WIDTH)) begin
      wlim = (AW+1)'(MAX_WIDTH);
    end else begin
      wlim = (AW+1)'(image_width_i);
    end
  end

  always_comb begin
    row_inc0 = {1'b0, row_q} + 1'b1;
    if (in_req_i.frame_start) begin
      cur_c = '0;
      cur_r = '0;
    end else if ({1'b0, col_q} >= wlim) begin
      cur_c = '0;
      cur_r = (32'(row_inc0) >= 32'(MAX_HEIGHT)) ? '0 : row_inc0[RW-1:0];
    end else begin
      cur_c = col_q;
      cur_r = row_q;
    end
    row_inc1 = {1'b0, cur_r} + 1'b1;
    col_inc  = {1'b0, cur_c} + 1'b1;
    if (col_inc >= wlim) begin
      col_d = '0;
      row_d = (32'(row_inc1) >= 32'(MAX_HEIGHT)) ? '0 : row_inc1[RW-1:0];
    end else begin
      col_d = col_inc[AW-1:0];
      row_d = cur_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_c_q <= cur_c;
      pos_r_q <= cur_r;
      pix_q   <= in_req_i.pixel_value;
      emit_q  <= (32'(cur_r) >= 32'd4) && (32'(cur_c) >= 32'd4);
    end
  end

  cnv5_ram #(
    .Width(32),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(pos_c_q),
    .wdata_i({pix_q, ram_rdata[31:8]}),
    .re_i   (cmd_i.accept),
    .raddr_i(cur_c),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[4] <= {pix_q, ram_rdata};
    end
  end

  logic [2:0]             rsel_q, ksel_q;
  logic                   mdone_q, pv_q;
  logic [7:0]             wraw, psel;
  logic signed [WB-1:0]   wsel;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [SW-1:0]   pond_q;

  assign wraw = weights_i[rsel_q][8*ksel_q +: 8];
  assign wsel = signed'(wraw[WB-1:0]);
  assign psel = win_q[ksel_q][8*rsel_q +: 8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsel_q  <= '0;
      ksel_q  <= '0;
      mdone_q <= 1'b0;
      pv_q    <= 1'b0;
      acc_q   <= '0;
      pond_q  <= '0;
    end else if (cmd_i.mac_step) begin
      if (pv_q) begin
        acc_q <= acc_q + ACCW'(prod_q);
      end
      pv_q <= !mdone_q;
      if (!mdone_q) begin
        prod_q <= PW'(wsel) * PW'($signed({1'b0, psel}));
        pond_q <= pond_q + SW'(wsel);
        if (ksel_q == 3'd4) begin
          ksel_q <= '0;
          if (rsel_q == 3'd4) begin
            mdone_q <= 1'b1;
          end else begin
            rsel_q <= rsel_q + 3'd1;
          end
        end else begin
          ksel_q <= ksel_q + 3'd1;
        end
      end
    end
  end

  logic [ACCW-1:0] amag, quo_q;
  logic [SW-1:0]   dmag, rem_q;
  logic [SW:0]     sh;
  logic [SW+1:0]   trial;
  logic [CNTW-1:0] dcnt_q;

  assign amag  = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
  assign dmag  = pond_q[SW-1] ? SW'(-pond_q) : SW'(pond_q);
  assign sh    = {rem_q, quo_q[ACCW-1]};
  assign trial = {1'b0, sh} - {2'b0, dmag};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= amag;
      dcnt_q <= CNTW'(ACCW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (!trial[SW+1]) begin
        rem_q <= trial[SW-1:0];
        quo_q <= {quo_q[ACCW-2:0], 1'b1};
      end else begin
        rem_q <= sh[SW-1:0];
        quo_q <= {quo_q[ACCW-2:0], 1'b0};
      end
    end
  end

  logic [7:0]  res_pix;
  logic [31:0] crow, ccol;

  always_comb begin
    if (pond_q == '0) begin
      res_pix = (!acc_q[ACCW-1] && acc_q != '0) ? 8'd255 : 8'd0;
    end else if (acc_q[ACCW-1] ^ pond_q[SW-1]) begin
      res_pix = 8'd0;
    end else if (quo_q > ACCW'(255)) begin
      res_pix = 8'd255;
    end else begin
      res_pix = quo_q[7:0];
    end
    crow = 32'(pos_r_q) - 32'd2;
    ccol = 32'(pos_c_q) - 32'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_res_o.filtered_pixel <= res_pix;
      out_res_o.center_row     <= crow[10:0];
      out_res_o.center_col     <= ccol[10:0];
    end
  end

  assign sts_o.emit     = emit_q;
  assign sts_o.mac_done = mdone_q && !pv_q;
  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.out_free = !out_valid_o || !out_stall_i;
endmodule
`default_nettype wire

// ===== sv/conv5x5_gray_normalized.sv =====
// Top level of the normalized 5x5 convolution filter with its register port.
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid_i/in_stall_o | pix_req_t (pixel, frame start)
//   out     | result    | out_valid_o/out_stall_i | flt_res_t (pixel, row, col)
//   cfg     | APB r/w   | psel/penable/pready  | six registers at 8*i
//
// A border pixel is only accepted and loaded; a pixel with a full window also passes
// through one shared multiplier over the 25 taps and a one-bit-per-cycle divider,
// and then waits in the output state while the output stalls.
// The line store has no reset; a frame writes each line before a result uses it.
// A stalled result sits in the output register while the next request is taken.
`default_nettype none
module conv5x5_gray_normalized #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cnv5_pkg::pix_req_t in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cnv5_pkg::flt_res_t      out_res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import cnv5_pkg::*;

  logic [4:0][39:0] wrow_q;
  logic [11:0]      width_q;
  logic             cfg_we;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrow_q[0] <= RST_WROW;
      wrow_q[1] <= RST_WROW;
      wrow_q[2] <= RST_WROW2;
      wrow_q[3] <= RST_WROW;
      wrow_q[4] <= RST_WROW;
      width_q   <= RST_IMG_WIDTH;
    end else if (cfg_we) begin
      case (paddr[5:3])
        REG_WROW0: wrow_q[0] <= pwdata[39:0];
        REG_WROW1: wrow_q[1] <= pwdata[39:0];
        REG_WROW2: wrow_q[2] <= pwdata[39:0];
        REG_WROW3: wrow_q[3] <= pwdata[39:0];
        REG_WROW4: wrow_q[4] <= pwdata[39:0];
        REG_WIDTH: width_q   <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_WROW0: prdata = {24'd0, wrow_q[0]};
      REG_WROW1: prdata = {24'd0, wrow_q[1]};
      REG_WROW2: prdata = {24'd0, wrow_q[2]};
      REG_WROW3: prdata = {24'd0, wrow_q[3]};
      REG_WROW4: prdata = {24'd0, wrow_q[4]};
      REG_WIDTH: prdata = {52'd0, width_q};
      default:   prdata = '0;
    endcase
  end

  cnv5_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cnv5_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_req_i     (in_req_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .weights_i    (wrow_q),
    .image_width_i(width_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_res_o    (out_res_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy next cycle");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_one_load_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.load, cmd.mac_step, cmd.div_step, cmd.out_load}))
    else $error("controller issued conflicting datapath commands");
`endif
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the normalized 5x5 convolution filter.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cnv5_pkg::*;

  localparam int MAXW = 2048;
  localparam int MAXH = 2048;
  localparam int WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pix_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  flt_res_t out_res_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  conv5x5_gray_normalized dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state.
  logic [39:0] kern_rows [5];
  logic [11:0] img_width;
  logic [7:0] lines [4][MAXW];
  logic [39:0] win_cols [5];
  int unsigned row_pos, col_pos;
  flt_res_t filtered_q [$];

  int errors = 0;
  int sent = 0;
  int got = 0;
  int idle_snd = 0;
  int idle_rcv = 0;
  int wdog = 0;
  logic sink_on = 1'b1;

  function automatic int tap(int r, int k);
    logic signed [7:0] b;
    b = kern_rows[r][8*k +: 8];
    return int'(b);
  endfunction

  function automatic logic [7:0] convolve();
    longint acc, pond, q;
    int w;
    acc = 0;
    pond = 0;
    for (int r = 0; r < 5; r++) begin
      for (int k = 0; k < 5; k++) begin
        w = tap(r, k);
        acc += longint'(w) * longint'(win_cols[k][8*r +: 8]);
        pond += w;
      end
    end
    if (pond == 0) return (acc > 0) ? 8'd255 : 8'd0;
    q = acc / pond;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic void advance_row();
    col_pos = 0;
    row_pos++;
    if (row_pos >= MAXH) row_pos = 0;
  endfunction

  function automatic void predict_pixel(pix_req_t rq);
    int unsigned w;
    logic [39:0] col;
    flt_res_t res;
    w = img_width;
    if (w < 5) w = 5;
    if (w > MAXW) w = MAXW;
    if (rq.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end else if (col_pos >= w) begin
      advance_row();
    end
    for (int i = 0; i < 4; i++) col[8*i +: 8] = lines[i][col_pos];
    col[39:32] = rq.pixel_value;
    for (int i = 0; i < 3; i++) lines[i][col_pos] = lines[i+1][col_pos];
    lines[3][col_pos] = rq.pixel_value;
    for (int i = 0; i < 4; i++) win_cols[i] = win_cols[i+1];
    win_cols[4] = col;
    if (row_pos >= 4 && col_pos >= 4) begin
      res.filtered_pixel = convolve();
      res.center_row = 11'(row_pos - 2);
      res.center_col = 11'(col_pos - 2);
      filtered_q.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) advance_row();
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < REG_WIDTH) kern_rows[idx] = val[39:0];
    else if (idx == REG_WIDTH) img_width = val[11:0];
  endtask

  task automatic read_reg(logic [2:0] idx, output logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] pv, logic fs);
    while ($urandom_range(99) < idle_snd) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{pixel_value: pv, frame_start: fs};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel('{pixel_value: pv, frame_start: fs});
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Sends one whole frame: rows x width pixels starting with a frame start.
  task automatic send_frame(int rows, int w, int mode);
    logic [7:0] pv;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        case (mode)
          0: pv = 8'($urandom);
          1: pv = 8'hFF;
          2: pv = 8'h00;
          default: pv = ($urandom_range(1)) ? 8'hFF : 8'h00;
        endcase
        send_pixel(pv, (r == 0 && c == 0));
      end
    end
  endtask

  function automatic logic [39:0] rand_row();
    return {8'($urandom), 32'($urandom)};
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= sink_on ? ($urandom_range(99) < idle_rcv) : 1'b1;
    if (out_valid_o && !out_stall_i) begin
      got++;
      if (filtered_q.size() == 0) begin
        $error("result without pending expectation: %p", out_res_o);
        errors++;
      end else begin
        flt_res_t e;
        e = filtered_q.pop_front();
        if (e.filtered_pixel !== out_res_o.filtered_pixel) begin
          $error("filtered_pixel expected %0d got %0d", e.filtered_pixel,
                 out_res_o.filtered_pixel);
          errors++;
        end
        if (e.center_row !== out_res_o.center_row) begin
          $error("center_row expected %0d got %0d", e.center_row, out_res_o.center_row);
          errors++;
        end
        if (e.center_col !== out_res_o.center_col) begin
          $error("center_col expected %0d got %0d", e.center_col, out_res_o.center_col);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired, %0d results pending", filtered_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Directed rows: weight row set, width, frame rows, pixel pattern.
  typedef struct {
    logic [39:0] w0, w1, w2, w3, w4;
    logic [11:0] width;
    int rows;
    int mode;
  } plan_t;

  plan_t plan [] = '{
    '{40'h0, 40'h0, 40'h10000, 40'h0, 40'h0, 12'd5, 6, 0},
    '{40'h0101010101, 40'h0101010101, 40'h0101010101, 40'h0101010101,
      40'h0101010101, 12'd5, 5, 1},
    '{40'h7F7F7F7F7F, 40'h7F7F7F7F7F, 40'h7F7F7F7F7F, 40'h7F7F7F7F7F,
      40'h7F7F7F7F7F, 12'd6, 5, 3},
    '{40'h8080808080, 40'h8080808080, 40'h8080808080, 40'h8080808080,
      40'h8080808080, 12'd7, 5, 1},
    '{40'h0, 40'h0, 40'h01FF0000, 40'h0, 40'h0, 12'd5, 5, 3},
    '{40'h0, 40'h0, 40'h0000FF00, 40'h0, 40'h01, 12'd3, 5, 0},
    '{40'hFF, 40'h0, 40'h0, 40'h0, 40'h0, 12'd0, 5, 1},
    '{40'hFF, 40'h0, 40'h0, 40'h0, 40'h0, 12'd1, 5, 0}
  };

  initial begin
    plan_t p;
    int w, seg;
    logic [63:0] rv, rexp;
    kern_rows = '{RST_WROW, RST_WROW, RST_WROW2, RST_WROW, RST_WROW};
    img_width = RST_IMG_WIDTH;
    for (int i = 0; i < 4; i++) for (int j = 0; j < MAXW; j++) lines[i][j] = '0;
    for (int i = 0; i < 5; i++) win_cols[i] = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Register values after reset.
    for (int i = 0; i < 6; i++) begin
      read_reg(3'(i), rv);
      if (i == REG_WIDTH) rexp = 64'(RST_IMG_WIDTH);
      else if (i == REG_WROW2) rexp = 64'(RST_WROW2);
      else rexp = 64'(RST_WROW);
      if (rv !== rexp) begin
        $error("register %0d expected %0h got %0h", i, rexp, rv);
        errors++;
      end
    end

    // Reset kernel is identity: a small image of constant 200.
    write_reg(REG_WIDTH, 12'd8);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 8; c++) send_pixel(8'd200, (r == 0 && c == 0));
    drain();
    if (got != 4) begin
      $error("result count expected %0d got %0d", 4, got);
      errors++;
    end

    foreach (plan[i]) begin
      p = plan[i];
      write_reg(REG_WROW0, p.w0);
      write_reg(REG_WROW1, p.w1);
      write_reg(REG_WROW2, p.w2);
      write_reg(REG_WROW3, p.w3);
      write_reg(REG_WROW4, p.w4);
      write_reg(REG_WIDTH, p.width);
      w = (p.width < 5) ? 5 : (p.width > MAXW ? MAXW : p.width);
      send_frame(p.rows, w, p.mode);
      drain();
    end

    // Width lowered mid-row: the next pixel begins a new row.
    write_reg(REG_WIDTH, 12'd8);
    send_frame(5, 8, 0);
    for (int c = 0; c < 6; c++) send_pixel(8'($urandom), 1'b0);
    drain();
    write_reg(REG_WIDTH, 12'd5);
    for (int c = 0; c < 30; c++) send_pixel(8'($urandom), 1'b0);
    drain();

    for (seg = 0; seg < 10; seg++) begin
      case (seg % 4)
        0: begin idle_snd = 0;  idle_rcv = 0;  end
        1: begin idle_snd = 57; idle_rcv = 0;  end
        2: begin idle_snd = 0;  idle_rcv = 57; end
        default: begin idle_snd = 7; idle_rcv = 7; end
      endcase
      for (int r = 0; r < 5; r++) write_reg(3'(r), rand_row());
      if ($urandom_range(3) == 0) write_reg(REG_WROW0, 40'h0);
      w = $urandom_range(5, 12);
      write_reg(REG_WIDTH, 12'(w));
      for (int f = 0; f < 3; f++) begin
        send_frame($urandom_range(5, 8), w, $urandom_range(9) == 0 ? 3 : 0);
        if ($urandom_range(4) == 0) send_pixel(8'($urandom), 1'b1);
      end
      // Hold results back, then let them all drain before sending more.
      in_valid_i <= 1'b0;
      sink_on = 1'b0;
      repeat (50) @(posedge clk_i);
      sink_on = 1'b1;
      drain();
    end
    idle_snd = 0;
    idle_rcv = 0;
    drain();

    $display("%0d pixels sent, %0d filtered results checked over several kernels and widths",
             sent, got);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
